>>> rtl/core/integrate_fire_network_event_step_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integrate-and-fire event network
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef INTEGRATE_FIRE_NETWORK_EVENT_STEP_ASSERT_SVH
`define INTEGRATE_FIRE_NETWORK_EVENT_STEP_ASSERT_SVH

// property must hold at every enabled clock edge
`define IFNES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true
`define IFNES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/ifnes_pkg.sv
// ---------------------------------------------------------------------------
// ifnes_pkg
// Types, constants and decay factors of the integrate-and-fire event network.
// ---------------------------------------------------------------------------
package ifnes_pkg;

  // request opcodes
  typedef enum logic [2:0] {
    OP_WR_ROW  = 3'd0,
    OP_WR_VOLT = 3'd1,
    OP_DRIVE   = 3'd2,
    OP_RD_CNT  = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DRIVE    = 2'd0,
    CFG_COUPLING = 2'd1,
    CFG_ACTIVE   = 2'd2
  } cfg_reg_e;

  // result kinds
  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_REPLY,
    ST_DEC_RD,
    ST_DEC_LOAD,
    ST_DEC_MUL,
    ST_DEC_WR,
    ST_DRV_RD,
    ST_DRV_ADD,
    ST_POP,
    ST_FIRE_RD,
    ST_FIRE_WR,
    ST_NB_SCAN,
    ST_NB_UPD,
    ST_EMIT
  } state_e;

  localparam int unsigned VW = 18;   // voltage, Q2.16
  localparam int unsigned CW = 32;   // spike count
  localparam int unsigned NW = 7;    // neuron counts
  localparam int unsigned FW = 24;   // decay factor, Q0.24

  localparam logic [VW-1:0] VMAX    = 18'h3FFFF;
  localparam logic [VW-1:0] VTHRESH = 18'h10000;

  localparam int unsigned DECAY_CUTOFF = 12;
  localparam logic [31:0] DECAY_LIMIT  = 32'(DECAY_CUTOFF) << 16;
  localparam logic [4:0]  DECAY_LAST   = 5'd20;   // 16 fraction + 5 integer steps

  localparam logic [15:0]   DRIVE_RST    = 16'd1311;
  localparam logic [15:0]   COUPLING_RST = 16'd2048;
  localparam logic [NW-1:0] ACTIVE_RST   = 7'd64;

  // exp(-2^e) in Q0.24; steps 0..15 are 2^-1..2^-16, 16..20 are 2^0..2^4
  function automatic logic [FW-1:0] decay_factor(input logic [4:0] k);
    logic [FW-1:0] f;
    unique case (k)
      5'd0:  f = 24'd10175896;
      5'd1:  f = 24'd13066109;
      5'd2:  f = 24'd14805841;
      5'd3:  f = 24'd15760736;
      5'd4:  f = 24'd16261035;
      5'd5:  f = 24'd16517109;
      5'd6:  f = 24'd16646655;
      5'd7:  f = 24'd16711808;
      5'd8:  f = 24'd16744480;
      5'd9:  f = 24'd16760840;
      5'd10: f = 24'd16769026;
      5'd11: f = 24'd16773120;
      5'd12: f = 24'd16775168;
      5'd13: f = 24'd16776192;
      5'd14: f = 24'd16776704;
      5'd15: f = 24'd16776960;
      5'd16: f = 24'd6171993;
      5'd17: f = 24'd2270549;
      5'd18: f = 24'd307285;
      5'd19: f = 24'd5628;
      5'd20: f = 24'd2;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/ifnes_ram.sv
// ---------------------------------------------------------------------------
// ifnes_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module ifnes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/integrate_fire_network_event_step.sv
// ---------------------------------------------------------------------------
// integrate_fire_network_event_step
// Event-driven network of leaky integrate-and-fire neurons held in RAMs.
// ---------------------------------------------------------------------------
// Writes and clear finish when accepted; a count read passes issue and reply.
// A drive reads and adds to its target, after, when time has moved, a decay of
// each active neuron: read, load, multiply steps (skipped past the cutoff; one
// Q0.24 multiply per step) and write. A fired neuron is popped and written, then
// active neurons are scanned, unlocked neighbours updated in the voltage RAM.
// One request at a time. Reset clears all state at once through valid bits.
module integrate_fire_network_event_step #(
  parameter int unsigned NEURONS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] neuron_index, [37:6] event_time, [101:38] row_bits,
  // [119:102] voltage_value
  input  logic [119:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] reported_neuron, [37:6] count_value, [39:38] zero
  output logic [39:0]  m_axis_tdata,
  // [0] result_kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned VW = ifnes_pkg::VW;
  localparam int unsigned CW = ifnes_pkg::CW;
  localparam int unsigned NW = ifnes_pkg::NW;
  localparam logic [NW-1:0] NMAX = NW'(NEURONS);

  // request fields
  logic [5:0]          in_idx;
  logic [31:0]         in_time;
  logic [NEURONS-1:0]  in_row;
  logic [VW-1:0]       in_volt;
  ifnes_pkg::opcode_e  in_op;
  logic                in_idx_ok;

  assign in_idx    = s_axis_tdata[5:0];
  assign in_time   = s_axis_tdata[37:6];
  assign in_row    = s_axis_tdata[38 +: NEURONS];
  assign in_volt   = s_axis_tdata[119:102];
  assign in_op     = ifnes_pkg::opcode_e'(s_axis_tuser);
  assign in_idx_ok = ({1'b0, in_idx} < NMAX);

  // registers
  ifnes_pkg::state_e state_q, state_d;
  logic [5:0]         idx_q, idx_d;
  logic [31:0]        dt_q, dt_d;
  logic [31:0]        last_time_q, last_time_d;
  logic [15:0]        drive_q, coup_q;
  logic [NW-1:0]      act_q;
  logic [NW-1:0]      i_q, i_d;
  logic [4:0]         k_q, k_d;
  logic [VW-1:0]      acc_q, acc_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [NEURONS-1:0] adj_q, adj_d;
  logic [NEURONS-1:0] lock_q, lock_d;
  logic [NW-1:0]      depth_q, depth_d;
  logic [NEURONS-1:0] vv_q, av_q, cv_q;
  logic               cnt_clr;
  logic               v_rv_q, a_rv_q, c_rv_q;
  logic               out_valid_q, out_valid_d;
  logic               out_kind_q, out_kind_d;
  logic [5:0]         out_idx_q, out_idx_d;
  logic [CW-1:0]      out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;

  // RAM ports
  logic           v_we, a_we, c_we, s_we;
  logic [AW-1:0]  v_waddr, a_waddr, c_waddr, s_waddr;
  logic [AW-1:0]  v_raddr, a_raddr, c_raddr, s_raddr;
  logic [VW-1:0]  v_wdata, v_rdata, v_rd;
  logic [NEURONS-1:0] a_wdata, a_rdata, a_rd;
  logic [CW-1:0]  c_wdata, c_rdata, c_rd;
  logic [AW-1:0]  s_wdata, s_rdata;

  // active count clamped to 1..NEURONS
  logic [NW-1:0] n_act;
  always_comb begin
    priority if (act_q == '0) begin
      n_act = NW'(1);
    end else if (act_q > NMAX) begin
      n_act = NMAX;
    end else begin
      n_act = act_q;
    end
  end

  // decay step: select dt bit and multiply with rounding
  logic [4:0]  dt_sel;
  logic        dt_bit;
  logic [41:0] prod;
  logic [41:0] prod_rnd;
  assign dt_sel   = (k_q < 5'd16) ? (5'd15 - k_q) : k_q;
  assign dt_bit   = dt_q[dt_sel];
  assign prod     = 42'(acc_q) * 42'(ifnes_pkg::decay_factor(k_q));
  assign prod_rnd = prod + 42'(24'h800000);

  // saturating voltage adds
  logic [VW:0]   drv_sum, cpl_sum;
  logic [VW-1:0] drv_sat, cpl_sat;
  assign drv_sum = {1'b0, v_rd} + (VW+1)'(drive_q);
  assign cpl_sum = {1'b0, v_rd} + (VW+1)'(coup_q);
  assign drv_sat = drv_sum[VW] ? ifnes_pkg::VMAX : drv_sum[VW-1:0];
  assign cpl_sat = cpl_sum[VW] ? ifnes_pkg::VMAX : cpl_sum[VW-1:0];

  // never-written entries read as zero
  assign v_rd = v_rv_q ? v_rdata : '0;
  assign a_rd = a_rv_q ? a_rdata : '0;
  assign c_rd = c_rv_q ? c_rdata : '0;

  logic [NW-1:0] depth_dec;
  logic [AW-1:0] i_a;
  logic          out_free;
  assign depth_dec = depth_q - NW'(1);
  assign i_a       = i_q[AW-1:0];
  assign out_free  = !out_valid_q || m_axis_tready;

  // read addresses; a count read holds its address while the reply waits
  assign v_raddr = (state_q == ifnes_pkg::ST_DRV_RD) ? idx_q[AW-1:0] : i_a;
  assign s_raddr = depth_dec[AW-1:0];
  assign a_raddr = s_rdata;
  assign c_raddr = (state_q == ifnes_pkg::ST_RD_ISSUE || state_q == ifnes_pkg::ST_RD_REPLY)
                   ? idx_q[AW-1:0] : s_rdata;

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    dt_d        = dt_q;
    last_time_d = last_time_q;
    i_d         = i_q;
    k_d         = k_q;
    acc_d       = acc_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    adj_d       = adj_q;
    lock_d      = lock_q;
    depth_d     = depth_q;
    cnt_clr     = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_idx_d   = out_idx_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    v_we = 1'b0; v_waddr = i_a;       v_wdata = acc_q;
    a_we = 1'b0; a_waddr = in_idx[AW-1:0]; a_wdata = in_row;
    c_we = 1'b0; c_waddr = cur_q;     c_wdata = cnt_q;
    s_we = 1'b0; s_waddr = depth_q[AW-1:0]; s_wdata = i_a;
    s_axis_tready = (state_q == ifnes_pkg::ST_IDLE);

    unique case (state_q)
      ifnes_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          idx_d = in_idx;
          unique case (in_op)
            ifnes_pkg::OP_WR_ROW: begin
              a_we = in_idx_ok;
            end
            ifnes_pkg::OP_WR_VOLT: begin
              v_we    = in_idx_ok;
              v_waddr = in_idx[AW-1:0];
              v_wdata = in_volt;
            end
            ifnes_pkg::OP_RD_CNT: begin
              state_d = ifnes_pkg::ST_RD_ISSUE;
            end
            ifnes_pkg::OP_CLEAR: begin
              cnt_clr     = 1'b1;
              last_time_d = '0;
            end
            ifnes_pkg::OP_DRIVE: begin
              if ({1'b0, in_idx} < n_act) begin
                dt_d        = (in_time >= last_time_q) ? in_time - last_time_q : '0;
                last_time_d = in_time;
                i_d         = '0;
                state_d     = (in_time > last_time_q) ? ifnes_pkg::ST_DEC_RD
                                                      : ifnes_pkg::ST_DRV_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ifnes_pkg::ST_RD_ISSUE: state_d = ifnes_pkg::ST_RD_REPLY;
      ifnes_pkg::ST_RD_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ifnes_pkg::KIND_COUNT;
          out_idx_d   = idx_q;
          out_cnt_d   = ({1'b0, idx_q} < NMAX) ? c_rd : '0;
          out_last_d  = 1'b1;
          state_d     = ifnes_pkg::ST_IDLE;
        end
      end
      // decay of neuron i
      ifnes_pkg::ST_DEC_RD: state_d = ifnes_pkg::ST_DEC_LOAD;
      ifnes_pkg::ST_DEC_LOAD: begin
        k_d = '0;
        if (dt_q >= ifnes_pkg::DECAY_LIMIT) begin
          acc_d   = '0;
          state_d = ifnes_pkg::ST_DEC_WR;
        end else begin
          acc_d   = v_rd;
          state_d = ifnes_pkg::ST_DEC_MUL;
        end
      end
      ifnes_pkg::ST_DEC_MUL: begin
        if (dt_bit) begin
          acc_d = prod_rnd[41:24];
        end
        k_d = k_q + 5'd1;
        if (k_q == ifnes_pkg::DECAY_LAST) begin
          state_d = ifnes_pkg::ST_DEC_WR;
        end
      end
      ifnes_pkg::ST_DEC_WR: begin
        v_we = 1'b1;
        i_d  = i_q + NW'(1);
        state_d = (i_q + NW'(1) == n_act) ? ifnes_pkg::ST_DRV_RD : ifnes_pkg::ST_DEC_RD;
      end
      // drive the target neuron
      ifnes_pkg::ST_DRV_RD: state_d = ifnes_pkg::ST_DRV_ADD;
      ifnes_pkg::ST_DRV_ADD: begin
        v_we    = 1'b1;
        v_waddr = idx_q[AW-1:0];
        v_wdata = drv_sat;
        if (drv_sat > ifnes_pkg::VTHRESH) begin
          lock_d  = '0;
          lock_d[idx_q[AW-1:0]] = 1'b1;
          s_we    = 1'b1;
          s_waddr = '0;
          s_wdata = idx_q[AW-1:0];
          depth_d = NW'(1);
          state_d = ifnes_pkg::ST_POP;
        end else begin
          state_d = ifnes_pkg::ST_IDLE;
        end
      end
      // cascade: pop, fire, spread to neighbours
      ifnes_pkg::ST_POP: begin
        depth_d = depth_dec;
        state_d = ifnes_pkg::ST_FIRE_RD;
      end
      ifnes_pkg::ST_FIRE_RD: begin
        cur_d   = s_rdata;
        state_d = ifnes_pkg::ST_FIRE_WR;
      end
      ifnes_pkg::ST_FIRE_WR: begin
        cnt_d   = (c_rd == '1) ? c_rd : c_rd + CW'(1);
        adj_d   = a_rd;
        c_we    = 1'b1;
        c_wdata = (c_rd == '1) ? c_rd : c_rd + CW'(1);
        v_we    = 1'b1;
        v_waddr = cur_q;
        v_wdata = '0;
        i_d     = '0;
        state_d = ifnes_pkg::ST_NB_SCAN;
      end
      ifnes_pkg::ST_NB_SCAN: begin
        priority if (i_q == n_act) begin
          state_d = ifnes_pkg::ST_EMIT;
        end else if (i_a != cur_q && adj_q[i_a] && !lock_q[i_a]) begin
          state_d = ifnes_pkg::ST_NB_UPD;
        end else begin
          i_d = i_q + NW'(1);
        end
      end
      ifnes_pkg::ST_NB_UPD: begin
        v_we    = 1'b1;
        v_wdata = cpl_sat;
        if (cpl_sat >= ifnes_pkg::VTHRESH && depth_q < NMAX) begin
          s_we        = 1'b1;
          depth_d     = depth_q + NW'(1);
          lock_d[i_a] = 1'b1;
        end
        i_d     = i_q + NW'(1);
        state_d = ifnes_pkg::ST_NB_SCAN;
      end
      ifnes_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ifnes_pkg::KIND_FIRE;
          out_idx_d   = 6'(cur_q);
          out_cnt_d   = cnt_q;
          out_last_d  = (depth_q == '0);
          state_d     = (depth_q == '0) ? ifnes_pkg::ST_IDLE : ifnes_pkg::ST_POP;
        end
      end
      default: state_d = ifnes_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ifnes_pkg::ST_IDLE;
      last_time_q <= '0;
      lock_q      <= '0;
      depth_q     <= '0;
      vv_q        <= '0;
      av_q        <= '0;
      cv_q        <= '0;
      out_valid_q <= 1'b0;
      drive_q     <= ifnes_pkg::DRIVE_RST;
      coup_q      <= ifnes_pkg::COUPLING_RST;
      act_q       <= ifnes_pkg::ACTIVE_RST;
    end else begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
      lock_q      <= lock_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      if (v_we) vv_q[v_waddr] <= 1'b1;
      if (a_we) av_q[a_waddr] <= 1'b1;
      if (cnt_clr) begin
        cv_q <= '0;
      end else if (c_we) begin
        cv_q[c_waddr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (ifnes_pkg::cfg_reg_e'(cfg_index_i))
          ifnes_pkg::CFG_DRIVE:    drive_q <= cfg_data_i;
          ifnes_pkg::CFG_COUPLING: coup_q  <= cfg_data_i;
          ifnes_pkg::CFG_ACTIVE:   act_q   <= cfg_data_i[NW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload and read-valid capture
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    dt_q      <= dt_d;
    i_q       <= i_d;
    k_q       <= k_d;
    acc_q     <= acc_d;
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    adj_q     <= adj_d;
    out_kind_q <= out_kind_d;
    out_idx_q <= out_idx_d;
    out_cnt_q <= out_cnt_d;
    out_last_q <= out_last_d;
    v_rv_q    <= vv_q[v_raddr];
    a_rv_q    <= av_q[a_raddr];
    c_rv_q    <= cv_q[c_raddr];
  end

  // state memories
  ifnes_ram #(.WIDTH(VW), .DEPTH(NEURONS)) u_volt_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );
  ifnes_ram #(.WIDTH(NEURONS), .DEPTH(NEURONS)) u_adj_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  ifnes_ram #(.WIDTH(CW), .DEPTH(NEURONS)) u_cnt_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  ifnes_ram #(.WIDTH(AW), .DEPTH(NEURONS)) u_stack_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // outputs
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_idx_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

  // checks
  `include "integrate_fire_network_event_step_assert.svh"

  `IFNES_ASSERT_NEVER(a_depth_bound, depth_q > NMAX, "cascade stack overflow")
  `IFNES_ASSERT(a_fire_locked, state_q == ifnes_pkg::ST_FIRE_WR |-> lock_q[cur_q], "fired neuron not locked")
  `IFNES_ASSERT(a_upd_unlocked, state_q == ifnes_pkg::ST_NB_UPD |-> !lock_q[i_a], "locked neuron updated")
  `IFNES_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(state_q == ifnes_pkg::ST_EMIT || state_q == ifnes_pkg::ST_RD_REPLY), "result from wrong state")

endmodule

>>> test/integrate_fire_network_event_step_test.sv
// ---------------------------------------------------------------------------
// Integrate-and-fire event network testbench
// Drives load, drive, read and clear requests with bursty timing and checks
// every result against a cycle-free model of the neuron network kept in a
// scoreboard. Several configuration settings are visited, extremes included.
// ---------------------------------------------------------------------------
module integrate_fire_network_event_step_test;

  localparam int unsigned IDLE_LIMIT  = 60000;  // cycles with no handshake
  localparam int unsigned SETTLE_CYC  = 2000;   // covers a full decay pass
  localparam logic [2:0]  OP_SPARE_LO = 3'd5;   // first unused opcode
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;   // last unused opcode

  typedef struct {
    logic        kind;
    logic [5:0]  neuron;
    logic [31:0] count;
    logic        last;
  } fire_result_t;

  // Network model with its queue of pending results
  class fire_scoreboard;
    int unsigned     drive_amt, couple_amt, active_raw;
    int unsigned     volt [64];
    longint unsigned adj [64];
    int unsigned     spikes [64];
    int unsigned     last_t;
    fire_result_t    pending_q [$];
    int unsigned     errors, checked, fires, drives;
    int unsigned     frac_f [16] = '{10175896, 13066109, 14805841, 15760736, 16261035,
      16517109, 16646655, 16711808, 16744480, 16760840, 16769026, 16773120, 16775168,
      16776192, 16776704, 16776960};
    int unsigned     int_f [5] = '{6171993, 2270549, 307285, 5628, 2};

    function new();
      drive_amt  = 32'(ifnes_pkg::DRIVE_RST);
      couple_amt = 32'(ifnes_pkg::COUPLING_RST);
      active_raw = 32'(ifnes_pkg::ACTIVE_RST);
      foreach (volt[i]) begin
        volt[i] = 0; adj[i] = 0; spikes[i] = 0;
      end
      last_t = 0;
    endfunction

    function void set_cfg(ifnes_pkg::cfg_reg_e r, logic [15:0] d);
      case (r)
        ifnes_pkg::CFG_DRIVE:    drive_amt = 32'(d);
        ifnes_pkg::CFG_COUPLING: couple_amt = 32'(d);
        ifnes_pkg::CFG_ACTIVE:   active_raw = 32'(d[6:0]);
        default: ;
      endcase
    endfunction

    function int unsigned n_active();
      if (active_raw < 1) return 1;
      if (active_raw > 64) return 64;
      return active_raw;
    endfunction

    function int unsigned mul_round(int unsigned v, int unsigned c);
      longint unsigned p;
      p = longint'(v) * longint'(c) + (64'd1 << 23);
      return int'(p >> 24);
    endfunction

    function int unsigned leak(int unsigned v, logic [31:0] dt);
      if (dt >= ifnes_pkg::DECAY_LIMIT) return 0;
      for (int k = 0; k < 16; k++) if (dt[15-k]) v = mul_round(v, frac_f[k]);
      for (int k = 0; k < 5; k++) if (dt[16+k]) v = mul_round(v, int_f[k]);
      return v;
    endfunction

    function int unsigned sat_add(int unsigned v, int unsigned a);
      return (v + a > 32'(ifnes_pkg::VMAX)) ? 32'(ifnes_pkg::VMAX) : v + a;
    endfunction

    function void push(logic k, int unsigned n, int unsigned c, logic l);
      fire_result_t r;
      r.kind = k; r.neuron = n[5:0]; r.count = c; r.last = l;
      pending_q = {pending_q, r};
    endfunction

    // accepted request: update the network and queue what it produces
    function void note_request(logic [2:0] op, logic [5:0] idx, logic [31:0] t,
                               logic [63:0] row, logic [17:0] v);
      int unsigned     n, dt, cur, nres;
      int unsigned     stack [64];
      int unsigned     depth;
      longint unsigned locks;
      n = n_active();
      case (op)
        ifnes_pkg::OP_WR_ROW:  adj[idx] = row;
        ifnes_pkg::OP_WR_VOLT: volt[idx] = 32'(v);
        ifnes_pkg::OP_RD_CNT:  push(ifnes_pkg::KIND_COUNT, 32'(idx), spikes[idx], 1'b1);
        ifnes_pkg::OP_CLEAR: begin
          foreach (spikes[i]) spikes[i] = 0;
          last_t = 0;
        end
        ifnes_pkg::OP_DRIVE: begin
          if (32'(idx) < n) begin
            drives++;
            dt = (t >= last_t) ? t - last_t : 0;
            last_t = t;
            if (dt != 0) for (int i = 0; i < n; i++) volt[i] = leak(volt[i], dt);
            volt[idx] = sat_add(volt[idx], drive_amt);
            if (volt[idx] > 32'(ifnes_pkg::VTHRESH)) begin
              // last-in-first-out cascade, each neuron fires once
              locks = 64'd1 << idx;
              stack[0] = 32'(idx); depth = 1; nres = 0;
              while (depth > 0 && nres < 64) begin
                depth--;
                cur = stack[depth];
                if (spikes[cur] != 32'hFFFF_FFFF) spikes[cur]++;
                volt[cur] = 0;
                for (int i = 0; i < n; i++) begin
                  if (i == cur || !adj[cur][i] || locks[i]) continue;
                  volt[i] = sat_add(volt[i], couple_amt);
                  if (volt[i] >= 32'(ifnes_pkg::VTHRESH) && depth < 64) begin
                    stack[depth] = i; depth++;
                    locks[i] = 1'b1;
                  end
                end
                push(ifnes_pkg::KIND_FIRE, cur, spikes[cur], 1'b0);
                nres++; fires++;
              end
              pending_q[$].last = 1'b1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic kind, logic [5:0] neuron, logic [31:0] count, logic last);
      fire_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result neuron %0d", neuron));
        return;
      end
      e = pending_q.pop_front();
      if (kind !== e.kind || neuron !== e.neuron || count !== e.count || last !== e.last)
        report($sformatf("got kind %0b neuron %0d count %0d last %0b, want %0b %0d %0d %0b",
                         kind, neuron, count, last, e.kind, e.neuron, e.count, e.last));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  fire_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    sent = 0;
  int unsigned    idle_cyc = 0;
  int unsigned    stall_mode = 0;

  integrate_fire_network_event_step dut (.*);

  always #6 clk_i = ~clk_i;

  // result side: check, and stall in changing modes
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tlast);
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on handshake inactivity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", sb.pending_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_req(logic [2:0] op, logic [5:0] idx, logic [31:0] t,
                          logic [63:0] row, logic [17:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {v, row, t, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, idx, t, row, v);
    sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else burst_left--;
  endtask

  // block idle: all results in, then time for a silent decay pass
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(ifnes_pkg::cfg_reg_e r, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_cfg(r, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly well-formed cluster: wire a few neurons, charge some, drive them 1 to 3 times
  task automatic cluster();
    int unsigned n, base, k, tgt;
    logic [63:0] mask;
    n = sb.n_active();
    k = $urandom_range(1, (n < 6) ? n : 6);
    base = $urandom_range(0, n - k);
    mask = '0;
    for (int i = 0; i < k; i++) mask[base + i] = 1'b1;
    for (int i = 0; i < k; i++)
      send_req(ifnes_pkg::OP_WR_ROW, 6'(base + i), '0,
               ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : (mask & {$urandom, $urandom}),
               '0);
    for (int i = 0; i < k; i++)
      if ($urandom_range(0, 2) != 0)
        send_req(ifnes_pkg::OP_WR_VOLT, 6'(base + i), '0, '0,
                 18'($urandom_range(55000, 66000)));
    repeat ($urandom_range(1, 3)) begin
      tgt = base + $urandom_range(0, k - 1);
      send_req(ifnes_pkg::OP_DRIVE, 6'(tgt), sb.last_t + $urandom_range(0, 1024), '0, '0);
    end
    if ($urandom_range(0, 1)) send_req(ifnes_pkg::OP_RD_CNT, 6'(base), '0, '0, '0);
  endtask

  // anything the fields allow
  task automatic noise();
    logic [2:0] op;
    op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
         : 3'($urandom_range(ifnes_pkg::OP_WR_ROW, ifnes_pkg::OP_CLEAR));
    send_req(op, 6'($urandom), $urandom, {$urandom, $urandom}, 18'($urandom));
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned goal;
    goal = sent + items;
    while (sent < goal)
      if ($urandom_range(0, 9) < 7) cluster();
      else noise();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, extremes and each special case
    send_req(ifnes_pkg::OP_RD_CNT, 6'd0, '0, '0, '0);
    send_req(ifnes_pkg::OP_WR_ROW, 6'd63, '0, '1, '0);
    send_req(ifnes_pkg::OP_WR_ROW, 6'd0, '0, 64'h8000_0000_0000_0002, '0);
    send_req(ifnes_pkg::OP_WR_VOLT, 6'd63, '0, '0, ifnes_pkg::VMAX);
    send_req(ifnes_pkg::OP_WR_VOLT, 6'd1, '0, '0, 18'd65000);
    send_req(ifnes_pkg::OP_WR_VOLT, 6'd0, '0, '0, 18'd65535);
    send_req(ifnes_pkg::OP_DRIVE, 6'd0, 32'd0, '0, '0);        // no elapsed time
    send_req(ifnes_pkg::OP_DRIVE, 6'd63, 32'd1, '0, '0);       // saturated, fans out
    send_req(ifnes_pkg::OP_RD_CNT, 6'd63, '0, '0, '0);
    send_req(ifnes_pkg::OP_WR_VOLT, 6'd5, '0, '0, 18'd200000);
    send_req(ifnes_pkg::OP_DRIVE, 6'd5, 32'h0001_FFFF, '0, '0); // all but the lowest fraction bit
    send_req(ifnes_pkg::OP_DRIVE, 6'd5, 32'h0000_1000, '0, '0); // time runs backwards
    send_req(ifnes_pkg::OP_WR_VOLT, 6'd7, '0, '0, 18'd250000);
    send_req(ifnes_pkg::OP_DRIVE, 6'd7, 32'h000C_1000, '0, '0); // at the cutoff
    send_req(ifnes_pkg::OP_DRIVE, 6'd7, 32'hFFFF_FFFF, '0, '0);
    send_req(OP_SPARE_LO, 6'd1, '1, '1, '1);
    send_req(OP_SPARE_HI, 6'd2, '1, '1, '1);
    send_req(ifnes_pkg::OP_CLEAR, 6'd0, '0, '0, '0);
    send_req(ifnes_pkg::OP_RD_CNT, 6'd63, '0, '0, '0);
    settle();

    // small network, out-of-range drive is ignored
    write_cfg(ifnes_pkg::CFG_ACTIVE, 16'd1);
    write_cfg(ifnes_pkg::CFG_DRIVE, 16'hFFFF);
    write_cfg(ifnes_pkg::CFG_COUPLING, 16'hFFFF);
    send_req(ifnes_pkg::OP_DRIVE, 6'd3, 32'd50, '0, '0);
    send_req(ifnes_pkg::OP_DRIVE, 6'd0, 32'd60, '0, '0);
    send_req(ifnes_pkg::OP_DRIVE, 6'd0, 32'd61, '0, '0);
    random_phase(60);
    settle();

    // zero active count acts as one, zero steps
    write_cfg(ifnes_pkg::CFG_ACTIVE, 16'd0);
    write_cfg(ifnes_pkg::CFG_DRIVE, 16'd0);
    write_cfg(ifnes_pkg::CFG_COUPLING, 16'd0);
    random_phase(40);
    settle();

    // oversized active count acts as the full network
    write_cfg(ifnes_pkg::CFG_ACTIVE, 16'd127);
    write_cfg(ifnes_pkg::CFG_DRIVE, 16'd4000);
    write_cfg(ifnes_pkg::CFG_COUPLING, 16'd9000);
    random_phase(120);
    settle();

    write_cfg(ifnes_pkg::CFG_ACTIVE, 16'd64);
    write_cfg(ifnes_pkg::CFG_DRIVE, 16'd1311);
    write_cfg(ifnes_pkg::CFG_COUPLING, 16'd2048);
    random_phase(90);
    settle();

    write_cfg(ifnes_pkg::CFG_ACTIVE, 16'($urandom_range(2, 63)));
    write_cfg(ifnes_pkg::CFG_DRIVE, 16'($urandom));
    write_cfg(ifnes_pkg::CFG_COUPLING, 16'($urandom));
    random_phase(80);
    settle();

    $display("%0d requests sent, %0d drives taken, %0d firings predicted, %0d results checked",
             sent, sb.drives, sb.fires, sb.checked);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ifnes_pkg.sv
rtl/core/ifnes_ram.sv
rtl/core/integrate_fire_network_event_step.sv
test/integrate_fire_network_event_step_test.sv
